@@ src/ctg_pkg.sv @@
// Package with shared types and constants of the tone-squelch gate.
package ctg_pkg;

  localparam int SampleWidthDef = 16;
  localparam int CountWidthDef  = 12;
  localparam int RecWidth       = 48;
  localparam int SumWidth       = 44;
  localparam int PowWidth       = 32;
  localparam int CoefWidth      = 18;
  localparam int CorrWidth      = 17;
  localparam int RelWidth       = 16;
  localparam int CfgIdxWidth    = 3;
  localparam int CfgDataWidth   = 32;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_ENABLE    = 3'd0,
    CFG_LENGTH    = 3'd1,
    CFG_COEF      = 3'd2,
    CFG_CORR_RE   = 3'd3,
    CFG_CORR_IM   = 3'd4,
    CFG_ABS_THR   = 3'd5,
    CFG_REL_THR   = 3'd6
  } cfg_idx_e;

  localparam logic [CoefWidth-1:0] CoefReset   = 18'sd130000;
  localparam logic [CorrWidth-1:0] CorrReReset = 17'sd65535;
  localparam logic [PowWidth-1:0]  AbsThrReset = 32'd1000000;
  localparam logic [RelWidth-1:0]  RelThrReset = 16'd256;

  // Operand selector for the shared multiplier.
  typedef enum logic [1:0] {
    MUL_COEF = 2'd0,
    MUL_RE   = 2'd1,
    MUL_IM   = 2'd2
  } mul_sel_e;

endpackage

@@ src/ctg_front.sv @@
// Front part: drops items while disabled and classifies each kept item.
module ctg_front #(
  parameter int SampleWidth = ctg_pkg::SampleWidthDef,
  parameter int CountWidth  = ctg_pkg::CountWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    enable_i,
  input  logic [CountWidth-1:0]   block_length_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [SampleWidth-1:0]  tone_sample_i,
  input  logic [SampleWidth-1:0]  reference_sample_i,
  output logic                    q_valid_o,
  input  logic                    q_ready_i,
  output logic [2*SampleWidth:0]  q_data_o
);
  import ctg_pkg::*;

  // Two-entry queue; the sample counter is tracked here so classification
  // is known at entry. Entries hold {close, tone, ref}.
  logic [2*SampleWidth:0] mem_q [2];
  logic                   wp_q, rp_q;
  logic [1:0]             cnt_q;
  logic [CountWidth-1:0]  scnt_q;
  logic                   push, pop, close;

  assign in_ready_o = (cnt_q != 2'd2) || !enable_i;
  assign push       = in_valid_i && in_ready_o && enable_i;
  assign pop        = q_valid_o && q_ready_i;
  assign close      = !(scnt_q < block_length_i);
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_data_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= {close, tone_sample_i, reference_sample_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      cnt_q  <= 2'd0;
      scnt_q <= '0;
    end else begin
      if (push) begin
        wp_q   <= ~wp_q;
        scnt_q <= close ? '0 : scnt_q + 1'b1;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ src/ctg_back.sv @@
// Back part: recurrence, power sums, closing arithmetic and result register.
module ctg_back #(
  parameter int SampleWidth = ctg_pkg::SampleWidthDef,
  parameter int CountWidth  = ctg_pkg::CountWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [CountWidth-1:0]           block_length_i,
  input  logic [ctg_pkg::CoefWidth-1:0]   coef_i,
  input  logic [ctg_pkg::CorrWidth-1:0]   corr_re_i,
  input  logic [ctg_pkg::CorrWidth-1:0]   corr_im_i,
  input  logic [ctg_pkg::PowWidth-1:0]    abs_thr_i,
  input  logic [ctg_pkg::RelWidth-1:0]    rel_thr_i,
  input  logic                            q_valid_i,
  output logic                            q_ready_o,
  input  logic [2*SampleWidth:0]          q_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            gate_open_o,
  output logic                            measurement_done_o,
  output logic [ctg_pkg::PowWidth-1:0]    tone_power_o,
  output logic [ctg_pkg::PowWidth-1:0]    reference_power_o
);
  import ctg_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StMul   = 4'd1;
  localparam logic [3:0] StStep  = 4'd2;
  localparam logic [3:0] StCre   = 4'd3;
  localparam logic [3:0] StCim   = 4'd4;
  localparam logic [3:0] StSq    = 4'd5;
  localparam logic [3:0] StDiv   = 4'd6;
  localparam logic [3:0] StGate  = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;
  localparam logic [3:0] StRef   = 4'd9;
  localparam logic [3:0] StCmp   = 4'd10;
  localparam int DivW  = 2*RecWidth + 8;   // numerator width for tone power
  localparam int DenW  = 2*CountWidth;
  localparam int RNumW = SumWidth + 6;
  localparam int RDenW = CountWidth + 5;

  logic [3:0]                    st_q;
  logic signed [RecWidth-1:0]    s1_q, s2_q;
  logic [SumWidth-1:0]           sum_q;
  logic [CountWidth-1:0]         rcnt_q;
  logic [PowWidth-1:0]           tp_q, rp_q;
  logic                          done_q, gate_q;
  logic signed [SampleWidth-1:0] x_q, r_q;
  logic signed [RecWidth+1:0]    prod_q;   // rounded product
  logic signed [RecWidth+2:0]    a_q, b_q;
  logic [DivW-1:0]               num_q;
  logic [DivW-1:0]               quo_q;
  logic [7:0]                    it_q;
  logic [PowWidth+RelWidth-1:0]  relp_q;
  logic [RNumW-1:0]              rnum_q, rquo_q;
  logic [RNumW-1:0]              rrem_q;
  logic [DivW-1:0]               rem_q;

  // Shared multiplier: s1 * operand, rounded half up at bit 16; the
  // 48x18 product is split in two 24-bit halves, low half first.
  logic [1:0]                    msel_q;
  logic                          mph_q;
  logic signed [CoefWidth-1:0]   mop;
  logic signed [RecWidth+CoefWidth:0] macc_q;
  logic signed [24+CoefWidth:0]  mpart;
  logic [DenW-1:0]               den;
  logic [RDenW-1:0]              rden;

  always_comb begin
    case (mul_sel_e'(msel_q))
      MUL_COEF: mop = coef_i;
      MUL_RE:   mop = {corr_re_i[CorrWidth-1], corr_re_i};
      MUL_IM:   mop = {corr_im_i[CorrWidth-1], corr_im_i};
      default:  mop = coef_i;
    endcase
    if (!mph_q) begin
      mpart = $signed({1'b0, s1_q[23:0]}) * mop;
    end else begin
      mpart = $signed(s1_q[RecWidth-1:24]) * mop;
    end
  end

  assign den  = block_length_i * block_length_i;
  assign rden = rcnt_q * 5'd25;

  logic signed [RecWidth+CoefWidth:0] mfull;
  logic signed [RecWidth+2:0]         s0w;
  logic [SumWidth:0]                  sumw;
  logic [2*SampleWidth-1:0]           sq;
  logic [SampleWidth-1:0]             rmag;
  logic [DivW-1:0]                    trial;
  logic [RNumW-1:0]                   rtrial;

  assign mfull = macc_q + ($signed(mpart) <<< 24) + 65'sd32768;
  assign s0w   = $signed({{3{x_q[SampleWidth-1]}}, x_q}) + prod_q - s2_q;
  assign rmag  = r_q[SampleWidth-1] ? -r_q : r_q;
  assign sq    = rmag * rmag;
  assign sumw  = sum_q + sq;
  assign trial = {rem_q[DivW-2:0], num_q[DivW-1]};
  assign rtrial = {rrem_q[RNumW-2:0], rnum_q[RNumW-1]};

  assign q_ready_o   = (st_q == StIdle);
  assign out_valid_o = (st_q == StOut);
  assign gate_open_o = gate_q;
  assign measurement_done_o = done_q;
  assign tone_power_o      = tp_q;
  assign reference_power_o = rp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; s1_q <= '0; s2_q <= '0; sum_q <= '0; rcnt_q <= '0;
      tp_q <= '0; rp_q <= '0; done_q <= 1'b0; gate_q <= 1'b0;
      msel_q <= 2'd0; mph_q <= 1'b0;
    end else begin
      case (st_q)
        StIdle: if (q_valid_i) begin
          x_q    <= q_data_i[2*SampleWidth-1:SampleWidth];
          r_q    <= q_data_i[SampleWidth-1:0];
          done_q <= q_data_i[2*SampleWidth];
          msel_q <= MUL_COEF; mph_q <= 1'b0; macc_q <= '0;
          st_q   <= StMul;
        end
        StMul: begin
          if (!mph_q) begin
            macc_q <= mpart; mph_q <= 1'b1;
          end else begin
            prod_q <= (RecWidth+2)'(mfull >>> 16);
            mph_q  <= 1'b0; macc_q <= '0;
            case (msel_q)
              MUL_COEF: st_q <= done_q ? StCre : StStep;
              MUL_RE:   st_q <= StCim;
              default:  st_q <= StSq;
            endcase
          end
        end
        StStep: begin
          s2_q <= s1_q;
          if (s0w > $signed({3'b000, {(RecWidth-1){1'b1}}})) s1_q <= {1'b0, {(RecWidth-1){1'b1}}};
          else if (s0w < -$signed({3'b000, {(RecWidth-1){1'b1}}}) - 1)
            s1_q <= {1'b1, {(RecWidth-1){1'b0}}};
          else s1_q <= s0w[RecWidth-1:0];
          sum_q  <= sumw[SumWidth] ? '1 : sumw[SumWidth-1:0];
          rcnt_q <= rcnt_q + 1'b1;
          st_q   <= StGate;
        end
        StCre: begin
          a_q <= prod_q - s2_q;
          msel_q <= MUL_RE; st_q <= StMul;
        end
        StCim: begin
          a_q <= a_q - prod_q;
          msel_q <= MUL_IM; st_q <= StMul;
        end
        StSq: begin
          // Sequential squaring via the divider registers: exact value is
          // too wide for one multiplier, so it is built by shift-add.
          num_q <= '0; quo_q <= '0; it_q <= '0;
          a_q <= a_q[RecWidth+2] ? -a_q : a_q;
          b_q <= prod_q[RecWidth+1] ? -prod_q : prod_q;
          st_q <= StRef;
        end
        StRef: begin
          // Shift-add square of |a| and |b|, one bit per cycle.
          if (it_q < 8'(RecWidth+3)) begin
            if (a_q[it_q[5:0]]) num_q <= num_q + (DivW'(a_q) << it_q);
            if (b_q[it_q[5:0]]) quo_q <= quo_q + (DivW'(b_q) << it_q);
            it_q <= it_q + 1'b1;
          end else begin
            num_q <= (num_q + quo_q) << 2;
            rem_q <= '0; quo_q <= '0; it_q <= '0;
            rnum_q <= RNumW'(sum_q) * 6'd51; rrem_q <= '0; rquo_q <= '0;
            st_q <= StDiv;
          end
        end
        StDiv: begin
          // Restoring division, one quotient bit of each divider a cycle.
          if (it_q < 8'(DivW)) begin
            if (trial >= DivW'(den)) begin
              rem_q <= trial - DivW'(den); quo_q <= {quo_q[DivW-2:0], 1'b1};
            end else begin
              rem_q <= trial; quo_q <= {quo_q[DivW-2:0], 1'b0};
            end
            num_q <= num_q << 1;
            if (it_q < 8'(RNumW)) begin
              if (rtrial >= RNumW'(rden)) begin
                rrem_q <= rtrial - RNumW'(rden); rquo_q <= {rquo_q[RNumW-2:0], 1'b1};
              end else begin
                rrem_q <= rtrial; rquo_q <= {rquo_q[RNumW-2:0], 1'b0};
              end
              rnum_q <= rnum_q << 1;
            end
            it_q <= it_q + 1'b1;
          end else begin
            if (block_length_i == '0) tp_q <= '0;
            else if (|quo_q[DivW-1:PowWidth]) tp_q <= '1;
            else tp_q <= quo_q[PowWidth-1:0];
            if (rcnt_q == '0) rp_q <= '0;
            else if (|rquo_q[RNumW-1:PowWidth]) rp_q <= '1;
            else rp_q <= rquo_q[PowWidth-1:0];
            s1_q <= '0; s2_q <= '0; sum_q <= '0; rcnt_q <= '0;
            st_q <= StGate;
          end
        end
        StGate: begin
          relp_q <= rel_thr_i * rp_q;
          st_q <= StCmp;
        end
        StCmp: begin
          gate_q <= (tp_q > abs_thr_i) &&
                    ({{(RelWidth-8){1'b0}}, tp_q, 8'd0} > relp_q);
          st_q <= StOut;
        end
        StOut: if (out_ready_i) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule

@@ src/ctcss_goertzel_tone_gate.sv @@
// Top level of the tone-squelch gate built on a generalized Goertzel detector.
//
// Items enter on the in channel (tone_sample_i, reference_sample_i) with a
// valid/ready handshake and leave on the out channel as one result each:
// the gate decision, a flag for a closed measurement and the held powers.
// Configuration registers are written on the cfg channel by index; the user
// must write them only while the block is idle; the block itself does not
// enforce this. While enable is low, items are taken and dropped.
// A front queue of two entries classifies each item as a recurrence step
// or a closing step; the back part carries it out with one shared
// multiplier used in two halves per product. A closing step also runs the
// bit-serial squaring and the bit-serial division of the back part.
// The back part takes a new item only once the result of the last one
// has been taken. The front keeps accepting while the back works or while
// a result waits on a stalled receiver, until its queue is full.
// Reset restores the register defaults and clears all measurement state.
module ctcss_goertzel_tone_gate #(
  parameter int SampleWidth = ctg_pkg::SampleWidthDef,
  parameter int CountWidth  = ctg_pkg::CountWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ctg_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [ctg_pkg::CfgDataWidth-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [SampleWidth-1:0]            tone_sample_i,
  input  logic [SampleWidth-1:0]            reference_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              gate_open_o,
  output logic                              measurement_done_o,
  output logic [ctg_pkg::PowWidth-1:0]      tone_power_o,
  output logic [ctg_pkg::PowWidth-1:0]      reference_power_o
);
  import ctg_pkg::*;

  logic                   enable_q;
  logic [CountWidth-1:0]  length_q;
  logic [CoefWidth-1:0]   coef_q;
  logic [CorrWidth-1:0]   corr_re_q, corr_im_q;
  logic [PowWidth-1:0]    abs_thr_q;
  logic [RelWidth-1:0]    rel_thr_q;
  logic                   q_valid, q_ready;
  logic [2*SampleWidth:0] q_data;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b1;
      length_q  <= CountWidth'(1024);
      coef_q    <= CoefReset;
      corr_re_q <= CorrReReset;
      corr_im_q <= '0;
      abs_thr_q <= AbsThrReset;
      rel_thr_q <= RelThrReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ENABLE:  enable_q  <= cfg_data_i[0];
        CFG_LENGTH:  length_q  <= cfg_data_i[CountWidth-1:0];
        CFG_COEF:    coef_q    <= cfg_data_i[CoefWidth-1:0];
        CFG_CORR_RE: corr_re_q <= cfg_data_i[CorrWidth-1:0];
        CFG_CORR_IM: corr_im_q <= cfg_data_i[CorrWidth-1:0];
        CFG_ABS_THR: abs_thr_q <= cfg_data_i[PowWidth-1:0];
        CFG_REL_THR: rel_thr_q <= cfg_data_i[RelWidth-1:0];
        default: ;
      endcase
    end
  end

  ctg_front #(.SampleWidth(SampleWidth), .CountWidth(CountWidth)) u_front (
    .clk_i, .rst_ni, .enable_i(enable_q), .block_length_i(length_q),
    .in_valid_i, .in_ready_o, .tone_sample_i, .reference_sample_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  ctg_back #(.SampleWidth(SampleWidth), .CountWidth(CountWidth)) u_back (
    .clk_i, .rst_ni, .block_length_i(length_q), .coef_i(coef_q),
    .corr_re_i(corr_re_q), .corr_im_i(corr_im_q), .abs_thr_i(abs_thr_q),
    .rel_thr_i(rel_thr_q), .q_valid_i(q_valid), .q_ready_o(q_ready),
    .q_data_i(q_data), .out_valid_o, .out_ready_i, .gate_open_o,
    .measurement_done_o, .tone_power_o, .reference_power_o
  );
endmodule

@@ src/ctg_checker.sv @@
// Port-level checker of the tone-squelch gate and its bind statement.
module ctg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        measurement_done_i,
  input logic [31:0] tone_power_i,
  input logic [31:0] reference_power_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped");
  a_pow_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(tone_power_i)) else $error("power moved");
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(measurement_done_i))
    else $error("done flag moved");
  a_ref_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(reference_power_i)) else $error("ref moved");
endmodule

bind ctcss_goertzel_tone_gate ctg_checker u_chk (
  .clk_i, .rst_ni, .out_valid_i(out_valid_o), .out_ready_i,
  .measurement_done_i(measurement_done_o), .tone_power_i(tone_power_o),
  .reference_power_i(reference_power_o)
);

@@ bench/tb_top.sv @@
// Testbench for the tone-squelch gate: directed table, random phases, self-checking.
`timescale 1ns / 1ps

module tb_top;
  import ctg_pkg::*;

  // Clock and reset.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Configuration channel.
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxWidth-1:0]  cfg_index_i = CFG_ENABLE;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;

  // Sample channel.
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] tone_sample_i = '0;
  logic [15:0] reference_sample_i = '0;

  // Result channel.
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        gate_open_o;
  logic        measurement_done_o;
  logic [31:0] tone_power_o;
  logic [31:0] reference_power_o;

  ctcss_goertzel_tone_gate u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .tone_sample_i      (tone_sample_i),
    .reference_sample_i (reference_sample_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .gate_open_o        (gate_open_o),
    .measurement_done_o (measurement_done_o),
    .tone_power_o       (tone_power_o),
    .reference_power_o  (reference_power_o)
  );

  // This settle time covers a closing step with margin.
  localparam int SettleCycles = 300;
  localparam int ItemTarget   = 1900;

  // One gate decision together with the done flag and the held powers.
  typedef struct packed {
    logic        gate;
    logic        done;
    logic [31:0] tone;
    logic [31:0] refp;
  } gate_result_t;

  // One row of the directed table: either a register write or an item.
  typedef struct {
    bit           is_write;
    cfg_idx_e     idx;
    logic [31:0]  data;
    logic [15:0]  tone;
    logic [15:0]  refs;
    bit           typed;
    gate_result_t want;
  } stim_row_t;

  // Shadow copy of the registers.
  logic               sh_enable;
  logic [11:0]        sh_length;
  logic signed [17:0] sh_coef;
  logic signed [16:0] sh_corr_re;
  logic signed [16:0] sh_corr_im;
  logic [31:0]        sh_abs_thr;
  logic [15:0]        sh_rel_thr;

  // Shadow copy of the measurement state.
  logic signed [47:0] goertzel_s1;
  logic signed [47:0] goertzel_s2;
  logic [11:0]        tone_count;
  logic [43:0]        ref_energy;
  logic [11:0]        ref_count;
  logic [31:0]        held_tone;
  logic [31:0]        held_ref;

  gate_result_t pending_results[$];
  stim_row_t    directed[$];

  int err_count     = 0;
  int items_sent    = 0;
  int items_dropped = 0;
  int results_seen  = 0;
  int closes_seen   = 0;
  int gates_open    = 0;

  // Receiver behavior, steered by the stimulus process.
  bit rx_idles     = 1'b1;
  bit rx_long_hold = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    err_count++;
  endtask

  // Coefficient product s*c/2^16, rounded half up.
  function automatic logic signed [95:0] coef_mul(input logic signed [95:0] s,
                                                  input logic signed [95:0] c);
    logic signed [95:0] p;
    p = s * c + 96'sd32768;
    return p >>> 16;
  endfunction

  task automatic apply_register(input cfg_idx_e idx, input logic [31:0] data);
    case (idx)
      CFG_ENABLE:  sh_enable  = data[0];
      CFG_LENGTH:  sh_length  = data[11:0];
      CFG_COEF:    sh_coef    = data[17:0];
      CFG_CORR_RE: sh_corr_re = data[16:0];
      CFG_CORR_IM: sh_corr_im = data[16:0];
      CFG_ABS_THR: sh_abs_thr = data;
      CFG_REL_THR: sh_rel_thr = data[15:0];
      default: ;
    endcase
  endtask

  // Advances the detector by one accepted item and queues its result, if any.
  task automatic predict_gate(input logic signed [15:0] x, input logic signed [15:0] r);
    logic signed [95:0]  s0, g, a, b;
    logic signed [129:0] energy, divisor, quot;
    longint              rr, acc, rq;
    gate_result_t        res;
    if (!sh_enable) begin
      items_dropped++;
      return;
    end
    res.done = 1'b0;
    if (tone_count < sh_length) begin
      s0 = x + coef_mul(goertzel_s1, sh_coef) - goertzel_s2;
      if (s0 > 96'sh7FFF_FFFF_FFFF) s0 = 96'sh7FFF_FFFF_FFFF;
      if (s0 < -96'sh8000_0000_0000) s0 = -96'sh8000_0000_0000;
      goertzel_s2 = goertzel_s1;
      goertzel_s1 = s0[47:0];
      rr = r;
      acc = longint'(ref_energy) + rr * rr;
      ref_energy = (acc > 64'h0FFF_FFFF_FFFF) ? 44'hFFF_FFFF_FFFF : acc[43:0];
      tone_count++;
      ref_count++;
    end else begin
      // Closing step: complex correction, then normalized powers.
      g = coef_mul(goertzel_s1, sh_coef) - goertzel_s2;
      a = g - coef_mul(goertzel_s1, sh_corr_re);
      b = -coef_mul(goertzel_s1, sh_corr_im);
      if (sh_length == 0) begin
        held_tone = '0;
      end else begin
        energy  = 4 * (130'(a) * 130'(a) + 130'(b) * 130'(b));
        divisor = 130'(sh_length) * 130'(sh_length);
        quot    = energy / divisor;
        held_tone = (quot > 130'sh0FFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
      end
      if (ref_count == 0) begin
        held_ref = '0;
      end else begin
        rq = (longint'(ref_energy) * 51) / (longint'(ref_count) * 25);
        held_ref = (rq > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rq[31:0];
      end
      goertzel_s1 = '0;
      goertzel_s2 = '0;
      tone_count  = '0;
      ref_energy  = '0;
      ref_count   = '0;
      res.done    = 1'b1;
    end
    res.gate = (held_tone > sh_abs_thr) &&
               (64'(held_tone) * 256 > 64'(sh_rel_thr) * 64'(held_ref));
    res.tone = held_tone;
    res.refp = held_ref;
    pending_results.push_back(res);
  endtask

  // Stops offering items, waits until every queued result has come out,
  // then lets the block settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_register(idx, data);
  endtask

  // Offers one item, holds it until accepted, then idles for the given gap.
  task automatic send_sample(input logic [15:0] x, input logic [15:0] r, input int gap);
    in_valid_i         <= 1'b1;
    tone_sample_i      <= x;
    reference_sample_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    predict_gate(x, r);
    items_sent++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 3)) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Receiver: random stalls per result, plus one long hold on request.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = rx_idles ? $urandom_range(0, 14) : 0;
      if (rx_long_hold) begin
        rx_long_hold = 1'b0;
        gap = 400;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Result checker: every handshake on the output is compared with the oldest prediction.
  always @(posedge clk_i) begin
    gate_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item waiting for it");
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (measurement_done_o) closes_seen++;
        if (gate_open_o) gates_open++;
        if (gate_open_o !== want.gate)
          report_mismatch($sformatf("gate_open %0b, want %0b", gate_open_o, want.gate));
        if (measurement_done_o !== want.done)
          report_mismatch($sformatf("measurement_done %0b, want %0b",
                                    measurement_done_o, want.done));
        if (tone_power_o !== want.tone)
          report_mismatch($sformatf("tone_power %0d, want %0d", tone_power_o, want.tone));
        if (reference_power_o !== want.refp)
          report_mismatch($sformatf("reference_power %0d, want %0d",
                                    reference_power_o, want.refp));
      end
    end
  end

  // Builds an item row for the table; want is used only when typed is set.
  function automatic stim_row_t item_row(input logic [15:0] x, input logic [15:0] r,
                                         input bit typed, input gate_result_t want);
    stim_row_t row;
    row.is_write = 1'b0;
    row.idx      = CFG_ENABLE;
    row.data     = '0;
    row.tone     = x;
    row.refs     = r;
    row.typed    = typed;
    row.want     = want;
    return row;
  endfunction

  function automatic stim_row_t write_row(input cfg_idx_e idx, input logic [31:0] data);
    stim_row_t row;
    row = item_row('0, '0, 1'b0, '0);
    row.is_write = 1'b1;
    row.idx      = idx;
    row.data     = data;
    return row;
  endfunction

  // Main stimulus: reset, directed table, then random phases.
  initial begin
    int            phase_items, gap, hold_phase, pause_phase, phase;
    bit            busy_tx;
    gate_result_t  zero_res;
    gate_result_t  close_res;

    sh_enable = 1'b1;  sh_length = 12'd1024; sh_coef = CoefReset;
    sh_corr_re = CorrReReset; sh_corr_im = '0;
    sh_abs_thr = AbsThrReset; sh_rel_thr = RelThrReset;
    goertzel_s1 = '0; goertzel_s2 = '0; tone_count = '0;
    ref_energy = '0; ref_count = '0; held_tone = '0; held_ref = '0;

    zero_res  = '{gate: 1'b0, done: 1'b0, tone: 32'd0, refp: 32'd0};
    close_res = '{gate: 1'b0, done: 1'b1, tone: 32'd0, refp: 32'd0};

    // Right after reset nothing has been measured, so both powers read zero.
    directed.push_back(item_row(16'h0000, 16'h0000, 1'b1, zero_res));
    // Length zero: every item closes a measurement and tone power stays zero.
    // The first close still sees one silent reference sample, the second none.
    directed.push_back(write_row(CFG_LENGTH, 32'd0));
    directed.push_back(item_row(16'h7FFF, 16'h8000, 1'b1, close_res));
    directed.push_back(item_row(16'h8000, 16'h7FFF, 1'b1, close_res));
    // Length one with full-scale samples, then the closing step.
    directed.push_back(write_row(CFG_LENGTH, 32'd1));
    directed.push_back(item_row(16'h8000, 16'h7FFF, 1'b1, zero_res));
    directed.push_back(item_row(16'h0000, 16'h0000, 1'b0, '0));
    // Extreme coefficient and corrections, thresholds wide open.
    directed.push_back(write_row(CFG_COEF, 32'hFFFE_0000));
    directed.push_back(write_row(CFG_CORR_RE, 32'hFFFF_0000));
    directed.push_back(write_row(CFG_CORR_IM, 32'd65535));
    directed.push_back(write_row(CFG_ABS_THR, 32'd0));
    directed.push_back(write_row(CFG_REL_THR, 32'd0));
    directed.push_back(write_row(CFG_LENGTH, 32'd3));
    directed.push_back(item_row(16'h7FFF, 16'h7FFF, 1'b0, '0));
    directed.push_back(item_row(16'h8000, 16'h8000, 1'b0, '0));
    directed.push_back(item_row(16'h7FFF, 16'h0001, 1'b0, '0));
    directed.push_back(item_row(16'hFFFF, 16'hFFFF, 1'b0, '0));
    // Absolute threshold at full scale keeps the gate shut.
    directed.push_back(write_row(CFG_ABS_THR, 32'hFFFF_FFFF));
    directed.push_back(write_row(CFG_REL_THR, 32'd65535));
    directed.push_back(item_row(16'h1234, 16'h4321, 1'b0, '0));
    // Disabled items vanish without a result and leave the state alone.
    directed.push_back(write_row(CFG_ENABLE, 32'd0));
    directed.push_back(item_row(16'h7FFF, 16'h7FFF, 1'b0, '0));
    directed.push_back(item_row(16'h8000, 16'h8000, 1'b0, '0));
    directed.push_back(write_row(CFG_ENABLE, 32'd1));
    directed.push_back(item_row(16'h0100, 16'h0010, 1'b0, '0));
    // Length lowered in the middle of a measurement: the next item closes it.
    directed.push_back(write_row(CFG_LENGTH, 32'd4095));
    directed.push_back(write_row(CFG_COEF, 32'd131071));
    directed.push_back(item_row(16'h7FFF, 16'h0800, 1'b0, '0));
    directed.push_back(item_row(16'h7FFF, 16'h0800, 1'b0, '0));
    directed.push_back(item_row(16'h7FFF, 16'h0800, 1'b0, '0));
    directed.push_back(write_row(CFG_LENGTH, 32'd2));
    directed.push_back(write_row(CFG_ABS_THR, 32'd0));
    directed.push_back(write_row(CFG_REL_THR, 32'd1));
    directed.push_back(item_row(16'h0000, 16'h0000, 1'b0, '0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table. Typed rows must agree with the predictor first.
    foreach (directed[i]) begin
      if (directed[i].is_write) begin
        wait_drained();
        write_register(directed[i].idx, directed[i].data);
      end else begin
        send_sample(directed[i].tone, directed[i].refs, $urandom_range(0, 3));
        if (directed[i].typed && pending_results.size() != 0 &&
            pending_results[$] !== directed[i].want)
          report_mismatch($sformatf("directed row %0d disagrees with its typed result", i));
      end
    end
    wait_drained();

    // Random phases: a fresh register setting each time, mostly short blocks.
    hold_phase  = 3;
    pause_phase = 6;
    phase = 0;
    while (items_sent - items_dropped < ItemTarget) begin
      wait_drained();
      write_register(CFG_ENABLE, ($urandom_range(0, 7) == 0) ? 32'd0 : 32'd1);
      case ($urandom_range(0, 19))
        0:       write_register(CFG_LENGTH, 32'd0);
        1:       write_register(CFG_LENGTH, 32'd4095);
        2:       write_register(CFG_LENGTH, $urandom_range(9, 40));
        default: write_register(CFG_LENGTH, $urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 3))
        0:       write_register(CFG_COEF, ($urandom_range(0, 1) != 0) ? 32'd131071
                                                                     : 32'hFFFE_0000);
        default: write_register(CFG_COEF, $urandom);
      endcase
      write_register(CFG_CORR_RE, $urandom);
      write_register(CFG_CORR_IM, $urandom);
      case ($urandom_range(0, 4))
        0:       write_register(CFG_ABS_THR, 32'd0);
        1:       write_register(CFG_ABS_THR, 32'hFFFF_FFFF);
        2:       write_register(CFG_ABS_THR, $urandom);
        default: write_register(CFG_ABS_THR, $urandom_range(0, 5000000));
      endcase
      case ($urandom_range(0, 4))
        0:       write_register(CFG_REL_THR, 32'd0);
        1:       write_register(CFG_REL_THR, 32'd65535);
        default: write_register(CFG_REL_THR, $urandom_range(0, 1024));
      endcase

      busy_tx  = $urandom_range(0, 2) != 0;
      rx_idles = $urandom_range(0, 2) != 0;
      phase_items = (sh_length == 12'd4095) ? 40 : $urandom_range(60, 120);
      if (!sh_enable) phase_items = 20;
      if (phase == hold_phase) begin
        rx_idles = 1'b1;
        rx_long_hold = 1'b1;
        busy_tx = 1'b0;
      end

      for (int k = 0; k < phase_items; k++) begin
        gap = busy_tx ? $urandom_range(0, 14) : 0;
        if (k == phase_items - 1) gap = 0;
        send_sample(pick_sample(), pick_sample(), gap);
        if (phase == pause_phase && k == phase_items / 2) begin
          in_valid_i <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk_i);
        end
      end
      in_valid_i <= 1'b0;

      // A long measurement is cut short by lowering the length.
      if (sh_length == 12'd4095) begin
        wait_drained();
        write_register(CFG_LENGTH, 32'd3);
        send_sample(pick_sample(), pick_sample(), 0);
        in_valid_i <= 1'b0;
      end
      phase++;
    end

    wait_drained();
    $display("Run covered %0d items (%0d dropped while disabled) over %0d phases.",
             items_sent, items_dropped, phase);
    $display("Checked %0d results: %0d closed measurements, %0d with the gate open.",
             results_seen, closes_seen, gates_open);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", err_count);
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
